FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on a clock that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/ubof_pkg.sv
// Types and constants of the descriptor bulk OUT finder.
package ubof_pkg;

  typedef enum logic [1:0] {
    ACT_FEED  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  localparam logic RK_SUMMARY = 1'b0;
  localparam logic RK_READ    = 1'b1;

  localparam logic [7:0] DT_INTERFACE = 8'h04;
  localparam logic [7:0] DT_ENDPOINT  = 8'h05;
  localparam logic [7:0] DT_VENDOR    = 8'h5F;
  localparam logic [7:0] CLASS_VENDOR = 8'hFF;
  localparam logic [1:0] XFER_BULK    = 2'b10;

  localparam logic [7:0] MIN_DESC_LEN = 8'd2;
  localparam logic [7:0] MIN_IF_LEN   = 8'd9;
  localparam logic [7:0] MIN_EP_LEN   = 8'd7;

  typedef struct packed {
    logic       kind;
    logic       found;
    logic [7:0] ep_addr;
    logic [15:0] max_pkt;
    logic       from_vendor;
    logic [6:0] vlen;
    logic [7:0] vbyte;
  } result_t;

endpackage

FILE: sv/usb_descriptor_bulk_out_finder.sv
// Top level of the USB descriptor bulk OUT finder.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per handshake: a
//   descriptor byte to feed (with last_i on the final byte of the stream), a
//   read of one captured vendor descriptor byte, or a clear of that capture.
//   Output channel (out_valid_o/out_ready_i) carries a scan summary after the
//   last byte, or the byte read back for a read item. Other items give no result.
// Result path: the item is held in the input register until it can move on,
//   and its result is then registered in the result register behind out_valid_o.
// Throughput: one item per cycle unless the output stalls. The input register
//   holds the item in work and the result register the finished result, so a
//   new item is taken while a result waits. The capture memory is read as the item is accepted.
// Reset: all parsing state, the chosen endpoint and the capture length clear
//   at once; capture memory contents are not cleared and are only readable
//   after being written.
// Stall: when out_ready_i stays low with a result pending, an item that
//   also makes a result waits in the input register and in_ready_o drops;
//   items that make no result still pass.
module usb_descriptor_bulk_out_finder #(
  parameter int VENDOR_CAPTURE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [5:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic        found_o,
  output logic [7:0]  endpoint_address_o,
  output logic [15:0] max_packet_size_o,
  output logic        from_vendor_interface_o,
  output logic [6:0]  vendor_desc_length_o,
  output logic [7:0]  vendor_byte_o
);
  import ubof_pkg::*;

  localparam int AW = $clog2(VENDOR_CAPTURE_BYTES);

  logic       s1_valid_q;
  logic [1:0] s1_action_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic [5:0] s1_index_q;

  logic       out_valid_q;
  result_t    res_q;

  logic       in_fire, s1_fire, has_result;
  result_t    res;
  logic       we;
  logic [AW-1:0] waddr;
  logic [7:0] wdata, rd_data;

  assign s1_fire    = s1_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_data_q   <= data_byte_i;
      s1_last_q   <= last_i;
      s1_index_q  <= read_index_i;
    end
  end

  ubof_vstore #(
    .DEPTH (VENDOR_CAPTURE_BYTES)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (AW'(read_index_i)),
    .rdata_o (rd_data)
  );

  ubof_parse #(
    .CAP_BYTES (VENDOR_CAPTURE_BYTES)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .action_i     (s1_action_q),
    .data_i       (s1_data_q),
    .last_i       (s1_last_q),
    .read_index_i (s1_index_q),
    .rd_data_i    (rd_data),
    .has_result_o (has_result),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      res_q <= res;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign result_kind_o           = res_q.kind;
  assign found_o                 = res_q.found;
  assign endpoint_address_o      = res_q.ep_addr;
  assign max_packet_size_o       = res_q.max_pkt;
  assign from_vendor_interface_o = res_q.from_vendor;
  assign vendor_desc_length_o    = res_q.vlen;
  assign vendor_byte_o           = res_q.vbyte;

endmodule

FILE: sv/ubof_vstore.sv
// Vendor descriptor capture memory: one write port, one registered read port.
module ubof_vstore #(
  parameter int DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a byte written in the same cycle is forwarded to the read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ubof_parse.sv
// Descriptor stream parser: per-stream state, endpoint choice and result forming.
module ubof_parse #(
  parameter int CAP_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    data_i,
  input  logic                          last_i,
  input  logic [5:0]                    read_index_i,
  input  logic [7:0]                    rd_data_i,
  output logic                          has_result_o,
  output ubof_pkg::result_t             res_o,
  output logic                          we_o,
  output logic [$clog2(CAP_BYTES)-1:0]  waddr_o,
  output logic [7:0]                    wdata_o
);
  import ubof_pkg::*;

  localparam int AW  = $clog2(CAP_BYTES);
  localparam int VLW = $clog2(CAP_BYTES + 1);
  localparam logic [7:0] CAP = 8'(CAP_BYTES);

  logic [7:0]       off_q, off_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       type_q, type_d;
  logic [3:0][7:0]  hdr_q, hdr_d;
  logic             stop_q, stop_d;
  logic [7:0]       alt_q, alt_d;
  logic             invend_q, invend_d;
  logic [7:0]       ep_q, ep_d;
  logic [15:0]      mps_q, mps_d;
  logic             epv_q, epv_d;
  logic [VLW-1:0]   vlen_q, vlen_d;

  logic [7:0] len_eff, type_eff;
  logic       take_byte, found;

  always_comb begin
    off_d    = off_q;
    len_d    = len_q;
    type_d   = type_q;
    hdr_d    = hdr_q;
    stop_d   = stop_q;
    alt_d    = alt_q;
    invend_d = invend_q;
    ep_d     = ep_q;
    mps_d    = mps_q;
    epv_d    = epv_q;
    vlen_d   = vlen_q;
    len_eff  = (off_q == 8'd0) ? data_i : len_q;
    type_eff = (off_q == 8'd1) ? data_i : type_q;
    take_byte = 1'b0;
    found    = 1'b0;
    res_o    = '0;
    unique case (action_i)
      ACT_FEED: begin
        if (!stop_q) begin
          if (off_q == 8'd0 && data_i < MIN_DESC_LEN) begin
            stop_d = 1'b1;
          end else begin
            take_byte = 1'b1;
            len_d  = len_eff;
            type_d = type_eff;
            if (off_q >= 8'd2 && off_q <= 8'd5) begin
              hdr_d[2'(off_q - 8'd2)] = data_i;
            end
            if ({1'b0, off_q} + 9'd1 >= {1'b0, len_eff}) begin
              off_d = 8'd0;
              // descriptor complete: apply it
              if (type_eff == DT_INTERFACE && len_eff >= MIN_IF_LEN) begin
                alt_d    = hdr_d[1];
                invend_d = (hdr_d[3] == CLASS_VENDOR);
              end else if (type_eff == DT_ENDPOINT && len_eff >= MIN_EP_LEN) begin
                if (hdr_d[1][1:0] == XFER_BULK && !hdr_d[0][7] && alt_q == 8'd0 &&
                    (ep_q == 8'd0 || (invend_q && !epv_q))) begin
                  ep_d  = hdr_d[0];
                  mps_d = {hdr_d[3], hdr_d[2]};
                  epv_d = invend_q;
                end
              end else if (type_eff == DT_VENDOR && vlen_q == '0) begin
                vlen_d = (len_eff <= CAP) ? VLW'(len_eff) : VLW'(CAP_BYTES);
              end
            end else begin
              off_d = off_q + 8'd1;
            end
          end
        end
        found             = (ep_d != 8'd0);
        res_o.kind        = RK_SUMMARY;
        res_o.found       = found;
        res_o.ep_addr     = found ? ep_d : 8'd0;
        res_o.max_pkt     = found ? mps_d : 16'd0;
        res_o.from_vendor = found && epv_d;
        res_o.vlen        = 7'(vlen_d);
        if (last_i) begin
          off_d    = 8'd0;
          len_d    = 8'd0;
          type_d   = 8'd0;
          hdr_d    = '0;
          stop_d   = 1'b0;
          alt_d    = 8'd0;
          invend_d = 1'b0;
          ep_d     = 8'd0;
          mps_d    = 16'd0;
          epv_d    = 1'b0;
        end
      end
      ACT_READ: begin
        res_o.kind = RK_READ;
        res_o.vlen = 7'(vlen_q);
        if ({2'b00, read_index_i} < 8'(vlen_q) && {2'b00, read_index_i} < CAP) begin
          res_o.vbyte = rd_data_i;
        end
      end
      ACT_CLEAR: begin
        vlen_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign has_result_o = (action_i == ACT_FEED && last_i) || (action_i == ACT_READ);
  assign we_o    = fire_i && take_byte && (vlen_q == '0) && (off_q < CAP);
  assign waddr_o = AW'(off_q);
  assign wdata_o = data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= 8'd0;
      len_q    <= 8'd0;
      type_q   <= 8'd0;
      hdr_q    <= '0;
      stop_q   <= 1'b0;
      alt_q    <= 8'd0;
      invend_q <= 1'b0;
      ep_q     <= 8'd0;
      mps_q    <= 16'd0;
      epv_q    <= 1'b0;
      vlen_q   <= '0;
    end else if (fire_i) begin
      off_q    <= off_d;
      len_q    <= len_d;
      type_q   <= type_d;
      hdr_q    <= hdr_d;
      stop_q   <= stop_d;
      alt_q    <= alt_d;
      invend_q <= invend_d;
      ep_q     <= ep_d;
      mps_q    <= mps_d;
      epv_q    <= epv_d;
      vlen_q   <= vlen_d;
    end
  end

endmodule

FILE: sv/ubof_checker.sv
// Port-level checker for the descriptor bulk OUT finder, bound to the top level.
`include "assert_macros.svh"

module ubof_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic        found_o,
  input logic [7:0]  endpoint_address_o,
  input logic [15:0] max_packet_size_o,
  input logic        from_vendor_interface_o,
  input logic [7:0]  vendor_byte_o
);

  // a pending result is held until taken
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // read replies carry no endpoint information
  `ASSERT_CLKD(a_read_clean, clk_i, rst_ni, out_valid_o && result_kind_o |-> !found_o && endpoint_address_o == 8'd0 && max_packet_size_o == 16'd0 && !from_vendor_interface_o, "read reply has endpoint fields")

  // summaries with nothing found carry no vendor byte and no endpoint details
  `ASSERT_CLKD(a_sum_clean, clk_i, rst_ni, out_valid_o && !result_kind_o && !found_o |-> endpoint_address_o == 8'd0 && max_packet_size_o == 16'd0 && !from_vendor_interface_o && vendor_byte_o == 8'd0, "empty summary has stale fields")

  // found means a nonzero endpoint address with the IN direction bit clear
  `ASSERT_CLKD(a_found_addr, clk_i, rst_ni, out_valid_o && found_o |-> endpoint_address_o != 8'd0 && !endpoint_address_o[7], "found with invalid address")

  // once reset has been seen at an edge, nothing is offered at the next one
  `ASSERT_CLK(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind usb_descriptor_bulk_out_finder ubof_checker u_ubof_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .out_valid_o             (out_valid_o),
  .out_ready_i             (out_ready_i),
  .result_kind_o           (result_kind_o),
  .found_o                 (found_o),
  .endpoint_address_o      (endpoint_address_o),
  .max_packet_size_o       (max_packet_size_o),
  .from_vendor_interface_o (from_vendor_interface_o),
  .vendor_byte_o           (vendor_byte_o)
);

FILE: bench/tb.sv
// Self-checking bench for the USB descriptor bulk OUT finder: random streams, reads and clears.
`timescale 1ns / 100ps

module tb;
  import ubof_pkg::*;

  localparam int CAP_BYTES = 64;
  localparam int CALM_ITEMS = 60;
  localparam int RANDOM_ITEMS = 220;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] EP_DIR_IN = 8'h80;

  typedef enum int {D_CONFIG, D_INTERFACE, D_ENDPOINT, D_VENDOR, D_OTHER} desc_kind_e;

  typedef struct {
    logic [1:0] action;
    logic [7:0] data;
    logic       last;
    logic [5:0] idx;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  act = ACT_FEED;
  logic [7:0]  dbyte = 8'h00;
  logic        feed_last = 1'b0;
  logic [5:0]  ridx = 6'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic        found;
  logic [7:0]  ep_addr;
  logic [15:0] max_pkt;
  logic        from_vendor;
  logic [6:0]  vlen;
  logic [7:0]  vbyte;

  usb_descriptor_bulk_out_finder #(
    .VENDOR_CAPTURE_BYTES(CAP_BYTES)
  ) DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .action_i               (act),
    .data_byte_i            (dbyte),
    .last_i                 (feed_last),
    .read_index_i           (ridx),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .result_kind_o          (kind),
    .found_o                (found),
    .endpoint_address_o     (ep_addr),
    .max_packet_size_o      (max_pkt),
    .from_vendor_interface_o(from_vendor),
    .vendor_desc_length_o   (vlen),
    .vendor_byte_o          (vbyte)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stim_t      in_items[$];
  result_t    replies_due[$];
  logic [7:0] desc_bytes[$];
  int         mismatches = 0;
  bit         in_taken = 1'b0;
  int         send_gap = 0;
  int         hold_gap = 0;

  // Scan state mirrored from the block
  int         pos;
  logic [7:0] dlen;
  logic [7:0] dtype;
  logic [7:0] hdr[4];
  logic       halted;
  logic [7:0] alt;
  logic       vend_if;
  logic [7:0] pick_addr;
  logic [15:0] pick_mps;
  logic       pick_vend;
  logic [7:0] cap_mem[CAP_BYTES];
  logic [7:0] cap_len;

  task automatic restart_scan();
    pos = 0;
    dlen = '0;
    dtype = '0;
    foreach (hdr[i]) hdr[i] = '0;
    halted = 1'b0;
    alt = '0;
    vend_if = 1'b0;
    pick_addr = '0;
    pick_mps = '0;
    pick_vend = 1'b0;
  endtask

  task automatic follow_item(input stim_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_FEED: begin
        if (!halted) begin
          if (pos == 0 && it.data < MIN_DESC_LEN) begin
            halted = 1'b1;
          end else begin
            if (pos == 0) dlen = it.data;
            else if (pos == 1) dtype = it.data;
            else if (pos <= 5) hdr[pos-2] = it.data;
            if (cap_len == 0 && pos < CAP_BYTES) cap_mem[pos] = it.data;
            if (pos + 1 >= int'(dlen)) begin
              // whole descriptor is in: apply it
              if (dtype == DT_INTERFACE && dlen >= MIN_IF_LEN) begin
                alt = hdr[1];
                vend_if = (hdr[3] == CLASS_VENDOR);
              end else if (dtype == DT_ENDPOINT && dlen >= MIN_EP_LEN) begin
                if (hdr[1][1:0] == XFER_BULK && (hdr[0] & EP_DIR_IN) == 8'h00 && alt == 0 &&
                    (pick_addr == 0 || (vend_if && !pick_vend))) begin
                  pick_addr = hdr[0];
                  pick_mps = {hdr[3], hdr[2]};
                  pick_vend = vend_if;
                end
              end else if (dtype == DT_VENDOR && cap_len == 0) begin
                cap_len = (dlen <= CAP_BYTES) ? dlen : 8'(CAP_BYTES);
              end
              pos = 0;
            end else begin
              pos = pos + 1;
            end
          end
        end
        if (it.last) begin
          r.kind = RK_SUMMARY;
          if (pick_addr != 0) begin
            r.found = 1'b1;
            r.ep_addr = pick_addr;
            r.max_pkt = pick_mps;
            r.from_vendor = pick_vend;
          end
          r.vlen = cap_len[6:0];
          replies_due.push_back(r);
          restart_scan();
        end
      end
      ACT_READ: begin
        r.kind = RK_READ;
        r.vlen = cap_len[6:0];
        if (it.idx < cap_len) r.vbyte = cap_mem[it.idx];
        replies_due.push_back(r);
      end
      ACT_CLEAR: cap_len = '0;
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: outputs and input handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    result_t w;
    stim_t   s;
    if (rst_ni) begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0h vlen %0h", $time,
                   kind, vlen);
          mismatches++;
        end else begin
          w = replies_due.pop_front();
          check_field("result_kind", w.kind, kind);
          check_field("found", w.found, found);
          check_field("endpoint_address", w.ep_addr, ep_addr);
          check_field("max_packet_size", w.max_pkt, max_pkt);
          check_field("from_vendor_interface", w.from_vendor, from_vendor);
          check_field("vendor_desc_length", w.vlen, vlen);
          check_field("vendor_byte", w.vbyte, vbyte);
        end
      end
      if (in_taken) begin
        s.action = act;
        s.data = dbyte;
        s.last = feed_last;
        s.idx = ridx;
        follow_item(s);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // Driver: next item or idle burst at the falling edge
  always @(negedge clk_i) begin
    stim_t cur;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (in_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else begin
        cur = in_items.pop_front();
        in_valid <= 1'b1;
        act <= cur.action;
        dbyte <= cur.data;
        feed_last <= cur.last;
        ridx <= cur.idx;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    if (hold_gap > 0) begin
      hold_gap--;
      out_ready <= 1'b0;
    end else if (in_items.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
      hold_gap = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic [1:0] a, input logic [7:0] d, input logic l,
                           input logic [5:0] i);
    stim_t s;
    s.action = a;
    s.data = d;
    s.last = l;
    s.idx = i;
    in_items.push_back(s);
  endtask

  task automatic add_feed(input logic [7:0] d, input logic l);
    push_item(ACT_FEED, d, l, 6'($urandom_range(0, 63)));
  endtask

  task automatic add_side_item();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      push_item(ACT_READ, 8'($urandom), 1'($urandom),
                ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15)) : 6'($urandom));
    end else if (r < 8) begin
      push_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom));
    end else begin
      push_item(ACT_UNUSED, 8'($urandom), 1'($urandom), 6'($urandom));
    end
  endtask

  task automatic build_desc(input desc_kind_e dk);
    logic [7:0] f[$];
    int len;
    int r;
    f = {};
    case (dk)
      D_CONFIG: begin
        len = 9;
        f = '{8'd9, DT_CONFIG};
      end
      D_INTERFACE: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 9;
        f = '{8'(len), DT_INTERFACE, 8'($urandom),
              ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 4)),
              ($urandom_range(0, 1) == 0) ? CLASS_VENDOR : 8'($urandom)};
      end
      D_ENDPOINT: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 10) : 7;
        r = $urandom_range(0, 9);
        f = '{8'(len), DT_ENDPOINT,
              (r == 0) ? 8'h00 : (r < 3) ? (EP_DIR_IN | 8'($urandom_range(0, 15)))
                                         : 8'($urandom_range(1, 15)),
              ($urandom_range(0, 3) != 0) ? {6'($urandom), XFER_BULK} : 8'($urandom)};
      end
      D_VENDOR: begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(41, 100) : $urandom_range(2, 40);
        f = '{8'(len), DT_VENDOR};
      end
      default: begin
        len = $urandom_range(2, 12);
        f = '{8'(len), 8'($urandom)};
      end
    endcase
    for (int i = 0; i < len; i++) desc_bytes.push_back((i < f.size()) ? f[i] : 8'($urandom));
  endtask

  task automatic emit_stream();
    for (int i = 0; i < desc_bytes.size(); i++) begin
      if ($urandom_range(0, 11) == 0) add_side_item();
      add_feed(desc_bytes[i], i == desc_bytes.size() - 1);
    end
  endtask

  task automatic make_stream();
    int n;
    int r;
    int cut;
    desc_bytes = {};
    if ($urandom_range(0, 1) == 0) build_desc(D_CONFIG);
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 30) build_desc(D_INTERFACE);
      else if (r < 65) build_desc(D_ENDPOINT);
      else if (r < 85) build_desc(D_VENDOR);
      else build_desc(D_OTHER);
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      // descriptor cut short by the final byte
      cut = $urandom_range(1, (desc_bytes.size() - 1 < 5) ? desc_bytes.size() - 1 : 5);
      repeat (cut) void'(desc_bytes.pop_back());
    end else if (r == 1) begin
      // bad length stops parsing; trailing bytes must be ignored
      desc_bytes.push_back(8'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 4)) desc_bytes.push_back(8'($urandom));
    end
    emit_stream();
  endtask

  initial begin
    int r;
    restart_scan();
    cap_len = '0;
    foreach (cap_mem[i]) cap_mem[i] = '0;

    // directed: reads with nothing held, unused action, clear
    push_item(ACT_READ, 8'h00, 1'b0, 6'd0);
    push_item(ACT_READ, 8'hFF, 1'b1, 6'd63);
    push_item(ACT_UNUSED, 8'hA5, 1'b1, 6'd21);
    push_item(ACT_CLEAR, 8'h5A, 1'b0, 6'd42);
    // zero length as the only byte
    add_feed(8'h00, 1'b1);
    // length one: rest of the stream ignored
    add_feed(8'h01, 1'b0);
    add_feed(8'h05, 1'b0);
    add_feed(8'hFF, 1'b1);
    // bulk OUT endpoint at extreme values, a short vendor capture, a truncated endpoint
    desc_bytes = '{8'h07, DT_ENDPOINT, 8'h7F, 8'h02, 8'hFF, 8'hFF, 8'h00,
                   8'h03, DT_VENDOR, 8'hAA, 8'h07, DT_ENDPOINT, 8'h01};
    foreach (desc_bytes[i]) add_feed(desc_bytes[i], i == desc_bytes.size() - 1);
    push_item(ACT_READ, 8'h00, 1'b0, 6'd2);
    push_item(ACT_READ, 8'h00, 1'b0, 6'd3);

    // widest vendor descriptor, capture clipped
    push_item(ACT_CLEAR, 8'h00, 1'b0, 6'd0);
    desc_bytes = '{8'hFF, DT_VENDOR};
    repeat (253) desc_bytes.push_back(8'($urandom));
    foreach (desc_bytes[i]) add_feed(desc_bytes[i], i == desc_bytes.size() - 1);
    push_item(ACT_READ, 8'h00, 1'b0, 6'd63);

    while (in_items.size() < RANDOM_ITEMS + 280) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        make_stream();
      end else if (r == 8) begin
        // noise: random actions and bytes
        repeat ($urandom_range(1, 10))
          push_item(2'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0), 6'($urandom));
        add_feed(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) add_side_item();
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (in_items.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: usb_descriptor_bulk_out_finder.f
+incdir+sv
sv/ubof_pkg.sv
sv/ubof_vstore.sv
sv/ubof_parse.sv
sv/usb_descriptor_bulk_out_finder.sv
sv/ubof_checker.sv
bench/tb.sv
